// ===== src/kabl_pkg.sv =====
// Shared constants and types of the k-th ancestor block.
package kabl_pkg;

  localparam int NODE_W   = 10;
  localparam int DIST_W   = 10;
  localparam int LEVELS   = 10;
  localparam int LVL_W    = 4;
  localparam int ADDR_W   = NODE_W + LVL_W;
  localparam int TBL_DEPTH = 1 << ADDR_W;
  localparam int ENTRY_W  = NODE_W + 1;

  localparam logic FUNC_LINK  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // One table entry: a node index plus the "none" mark.
  typedef struct packed {
    logic              none;
    logic [NODE_W-1:0] node;
  } entry_t;

  localparam entry_t NONE_ENTRY = '{none: 1'b1, node: '0};

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LINK  = 4'b0100,
    ST_QUERY = 4'b1000
  } state_t;

endpackage

// ===== src/kabl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module kabl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kth_ancestor_binary_lifting_top.sv =====
// Top level of the k-th ancestor unit built on a binary-lifting table.
//
// The block takes command words on start/func/node/parent/distance. A word is
// taken at a clock edge where start is high and busy is low. A link word
// (func = 0) stores parent as the level-0 ancestor of node and then derives
// levels 1 to 9 from the table, one level per cycle; it gives no result.
// A query word (func = 1) climbs from node by the set bits of distance,
// lowest bit first, and answers with ancestor and found, shown for exactly
// one cycle with done high. The receiver cannot stall, so results are
// never held back.
// Timing: a link keeps busy high while it walks levels 0 to 9 in order.
// A query keeps busy high while it handles the distance bits in order,
// and it stops early once it meets "none"; done rises at the same edge
// at which busy falls. The loop that limits both walks is the dependent
// read of the table memory, one read per cycle.
// After reset the table is swept to "none", one entry per cycle over all
// 16384 addresses, while busy stays high; no word is taken during the sweep.
module kth_ancestor_binary_lifting_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [kabl_pkg::NODE_W-1:0] node,
  input  logic [kabl_pkg::NODE_W-1:0] parent,
  input  logic [kabl_pkg::DIST_W-1:0] distance,
  output logic                        done,
  output logic [kabl_pkg::NODE_W-1:0] ancestor,
  output logic                        found
);

  kabl_pkg::state_t state, state_next;

  // Walk registers: the level being handled, the current ancestor and where
  // it comes from (a register or the memory output this cycle).
  logic [kabl_pkg::LVL_W-1:0]  lvl, lvl_next;
  kabl_pkg::entry_t            cur, cur_next;
  logic                        use_ram, use_ram_next;
  // The link walk writes and reads the same address when a node is its own
  // ancestor; the written entry is forwarded in place of the stale read.
  logic                        bypass, bypass_next;
  kabl_pkg::entry_t            byp_data, byp_data_next;
  logic [kabl_pkg::NODE_W-1:0] node_q, node_q_next;
  logic [kabl_pkg::DIST_W-1:0] dist_q, dist_q_next;
  logic [kabl_pkg::ADDR_W-1:0] clr_addr, clr_addr_next;

  logic                        done_next;
  logic [kabl_pkg::NODE_W-1:0] ancestor_next;
  logic                        found_next;

  logic                         ram_we;
  logic [kabl_pkg::ADDR_W-1:0]  ram_waddr;
  logic [kabl_pkg::ADDR_W-1:0]  ram_raddr;
  kabl_pkg::entry_t             ram_wdata;
  logic [kabl_pkg::ENTRY_W-1:0] ram_rdata;
  kabl_pkg::entry_t             cur_now;

  kabl_ram #(
    .WIDTH(kabl_pkg::ENTRY_W),
    .DEPTH(kabl_pkg::TBL_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy = (state != kabl_pkg::ST_IDLE);

  always_comb begin
    if (use_ram) begin
      cur_now = bypass ? byp_data : kabl_pkg::entry_t'(ram_rdata);
    end else begin
      cur_now = cur;
    end
  end

  always_comb begin
    state_next    = state;
    lvl_next      = lvl;
    cur_next      = cur;
    use_ram_next  = use_ram;
    bypass_next   = bypass;
    byp_data_next = byp_data;
    node_q_next   = node_q;
    dist_q_next   = dist_q;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    ancestor_next = ancestor;
    found_next    = found;
    ram_we        = 1'b0;
    ram_waddr     = {node_q, lvl};
    ram_wdata     = cur_now;
    ram_raddr     = {cur_now.node, lvl};

    unique case (state)
      kabl_pkg::ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = kabl_pkg::NONE_ENTRY;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == {kabl_pkg::ADDR_W{1'b1}}) begin
          state_next = kabl_pkg::ST_IDLE;
        end
      end
      kabl_pkg::ST_IDLE: begin
        if (start) begin
          node_q_next   = node;
          dist_q_next   = distance;
          lvl_next      = '0;
          use_ram_next  = 1'b0;
          bypass_next   = 1'b0;
          cur_next.none = 1'b0;
          if (func == kabl_pkg::FUNC_QUERY) begin
            cur_next.node = node;
            state_next    = kabl_pkg::ST_QUERY;
          end else begin
            cur_next.node = parent;
            state_next    = kabl_pkg::ST_LINK;
          end
        end
      end
      kabl_pkg::ST_LINK: begin
        // Write this level of the child's row, and read the next level's
        // ancestor from the row of the ancestor just written.
        ram_we = 1'b1;
        if (lvl == kabl_pkg::LVL_W'(kabl_pkg::LEVELS - 1)) begin
          state_next = kabl_pkg::ST_IDLE;
        end else begin
          lvl_next      = lvl + 1'b1;
          cur_next      = cur_now;
          use_ram_next  = !cur_now.none;
          bypass_next   = !cur_now.none && (cur_now.node == node_q);
          byp_data_next = cur_now;
        end
      end
      kabl_pkg::ST_QUERY: begin
        if (cur_now.none || (lvl == kabl_pkg::LVL_W'(kabl_pkg::LEVELS))) begin
          done_next     = 1'b1;
          found_next    = !cur_now.none;
          ancestor_next = cur_now.none ? '0 : cur_now.node;
          state_next    = kabl_pkg::ST_IDLE;
        end else begin
          lvl_next     = lvl + 1'b1;
          cur_next     = cur_now;
          use_ram_next = dist_q[lvl];
          bypass_next  = 1'b0;
        end
      end
      default: begin
        state_next = kabl_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kabl_pkg::ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      use_ram  <= 1'b0;
      bypass   <= 1'b0;
      lvl      <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
      use_ram  <= use_ram_next;
      bypass   <= bypass_next;
      lvl      <= lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    byp_data <= byp_data_next;
    node_q   <= node_q_next;
    dist_q   <= dist_q_next;
    ancestor <= ancestor_next;
    found    <= found_next;
  end

endmodule
